FILE: hdl/smf_pkg.sv
// Package: shared constants and types of the stereo fader/pan mixer.
`default_nettype none
package smf_pkg;
    localparam int MAX_FRAMES = 1024;
    localparam int POS_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int SMP_W      = 16;
    localparam int FADER_W    = 8;
    localparam int PAN_W      = 7;
    localparam int WGT_W      = 6;
    localparam int P1_W       = SMP_W + FADER_W;
    localparam int P2_W       = P1_W + WGT_W;
    localparam int MAG_W      = 28;
    localparam int DIV_C      = 8001;
    localparam int RECIP_SH   = 41;
    localparam int RECIP_W    = 29;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'((64'd1 << RECIP_SH) / DIV_C);
    localparam int PROD_W     = MAG_W + RECIP_W;
    localparam int Q_W        = PROD_W - RECIP_SH;
    localparam int REM_W      = 15;
    localparam logic [Q_W:0] SAT_POS = (Q_W+1)'((1 << (SMP_W - 1)) - 1);
    localparam logic [Q_W:0] SAT_NEG = (Q_W+1)'(1 << (SMP_W - 1));
    localparam logic signed [FADER_W-1:0] FADER_UNITY = FADER_W'(127);
    localparam logic signed [FADER_W-1:0] FADER_ALT   = '1;
    localparam logic [WGT_W-1:0] WGT_FULL = WGT_W'(63);
    localparam int Q_DEPTH    = 2;
    localparam int QPTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(Q_DEPTH + 1);
    localparam int PADDR_W    = 3;
    localparam logic REG_MIX_MODE = 1'b0;

    typedef struct packed {
        logic signed [SMP_W-1:0] left;
        logic signed [SMP_W-1:0] right;
        logic                    first;
        logic                    lastb;
        logic                    lastf;
        logic [POS_W-1:0]        pos;
    } t_job;
endpackage
`default_nettype wire

FILE: hdl/smf_if.sv
// Interfaces: input frame channel and mixed frame channel.
`default_nettype none
interface smf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [smf_pkg::SMP_W-1:0]      left_sample;
    logic signed [smf_pkg::SMP_W-1:0]      right_sample;
    logic signed [smf_pkg::FADER_W-1:0]    fader_level;
    logic signed [smf_pkg::PAN_W-1:0]      pan_position;
    logic                                  first_buffer;
    logic                                  last_buffer;
    logic                                  last_frame;
    modport source(output valid, left_sample, right_sample, fader_level, pan_position,
                   first_buffer, last_buffer, last_frame, input ready);
    modport sink(input valid, left_sample, right_sample, fader_level, pan_position,
                 first_buffer, last_buffer, last_frame, output ready);
endinterface

interface smf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [smf_pkg::SMP_W-1:0]  mixed_left;
    logic signed [smf_pkg::SMP_W-1:0]  mixed_right;
    logic                              frame_last;
    modport source(output valid, mixed_left, mixed_right, frame_last, input ready);
    modport sink(input valid, mixed_left, mixed_right, frame_last, output ready);
endinterface
`default_nettype wire

FILE: hdl/smf_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module smf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end
endmodule
`default_nettype wire

FILE: hdl/smf_front.sv
// Front end: accepts frames, tracks frame position, applies fader and pan gain when the mix mode is set.
`default_nettype none
module smf_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_mode,
    smf_in_if.sink                     i_in,
    input  wire logic                  i_full,
    output logic                       o_push,
    output smf_pkg::t_job              o_job
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL1  = 3'd1;
    localparam logic [2:0] ST_MUL2  = 3'd2;
    localparam logic [2:0] ST_ABS   = 3'd3;
    localparam logic [2:0] ST_RECIP = 3'd4;
    localparam logic [2:0] ST_REM   = 3'd5;
    localparam logic [2:0] ST_PUSH  = 3'd6;

    logic [2:0]                              r_state, n_state;
    logic [smf_pkg::POS_W-1:0]               r_pos;
    logic                                    r_mode;
    logic signed [smf_pkg::SMP_W-1:0]        r_smp   [2];
    logic signed [smf_pkg::FADER_W-1:0]      r_fader;
    logic signed [smf_pkg::PAN_W-1:0]        r_pan;
    logic                                    r_first, r_lastb, r_lastf;
    logic [smf_pkg::POS_W-1:0]               r_jpos;
    logic [smf_pkg::WGT_W-1:0]               r_w     [2];
    logic signed [smf_pkg::P1_W-1:0]         r_p1    [2];
    logic signed [smf_pkg::P2_W-1:0]         r_p2    [2];
    logic                                    r_neg   [2];
    logic [smf_pkg::MAG_W-1:0]               r_mag   [2];
    logic [smf_pkg::Q_W-1:0]                 r_q0    [2];
    logic [smf_pkg::REM_W-1:0]               r_rem   [2];

    logic                                    accept;
    logic signed [smf_pkg::FADER_W-1:0]      fader_eff;
    logic [smf_pkg::PAN_W-1:0]               pan_abs;
    logic [smf_pkg::WGT_W-1:0]               pan_mag;
    logic [smf_pkg::WGT_W-1:0]               w_dim;
    logic [smf_pkg::WGT_W-1:0]               w_new   [2];
    logic [smf_pkg::Q_W:0]                   q_fin   [2];
    logic signed [smf_pkg::SMP_W-1:0]        scaled  [2];
    logic signed [smf_pkg::SMP_W-1:0]        res     [2];
    logic [smf_pkg::PROD_W-1:0]              prod    [2];

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        fader_eff = (r_fader == smf_pkg::FADER_ALT) ? smf_pkg::FADER_UNITY : r_fader;
        pan_abs   = r_pan[smf_pkg::PAN_W-1] ? 7'(-r_pan) : 7'(r_pan);
        pan_mag   = pan_abs[smf_pkg::PAN_W-1] ? smf_pkg::WGT_FULL : pan_abs[smf_pkg::WGT_W-1:0];
        w_dim     = smf_pkg::WGT_FULL - pan_mag;
        w_new[0]  = (!r_pan[smf_pkg::PAN_W-1] && (r_pan != '0)) ? w_dim : smf_pkg::WGT_FULL;
        w_new[1]  = r_pan[smf_pkg::PAN_W-1] ? w_dim : smf_pkg::WGT_FULL;
        for (int c = 0; c < 2; c++) begin
            prod[c]  = {{smf_pkg::RECIP_W{1'b0}}, r_mag[c]}
                       * {{smf_pkg::MAG_W{1'b0}}, smf_pkg::RECIP_K};
            q_fin[c] = {1'b0, r_q0[c]}
                       + (smf_pkg::Q_W+1)'(r_rem[c] >= smf_pkg::REM_W'(smf_pkg::DIV_C));
            if (r_neg[c]) begin
                scaled[c] = (q_fin[c] > smf_pkg::SAT_NEG) ? {1'b1, {(smf_pkg::SMP_W-1){1'b0}}}
                                                         : smf_pkg::SMP_W'(-q_fin[c]);
            end else begin
                scaled[c] = (q_fin[c] > smf_pkg::SAT_POS) ? {1'b0, {(smf_pkg::SMP_W-1){1'b1}}}
                                                         : q_fin[c][smf_pkg::SMP_W-1:0];
            end
            res[c] = r_mode ? scaled[c] : r_smp[c];
        end
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            ST_IDLE:  if (accept) n_state = ST_MUL1;
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_ABS;
            ST_ABS:   n_state = ST_RECIP;
            ST_RECIP: n_state = ST_REM;
            ST_REM:   n_state = ST_PUSH;
            ST_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    assign o_job = '{left: res[0], right: res[1], first: r_first, lastb: r_lastb,
                     lastf: r_lastf, pos: r_jpos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_pos <= (i_in.last_frame || r_pos == smf_pkg::POS_W'(smf_pkg::MAX_FRAMES - 1))
                         ? '0 : r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_smp[0] <= i_in.left_sample;
                    r_smp[1] <= i_in.right_sample;
                    r_fader  <= i_in.fader_level;
                    r_pan    <= i_in.pan_position;
                    r_first  <= i_in.first_buffer;
                    r_lastb  <= i_in.last_buffer;
                    r_lastf  <= i_in.last_frame;
                    r_jpos   <= r_pos;
                    r_mode   <= i_mode;
                end
            end
            ST_MUL1: begin
                for (int c = 0; c < 2; c++) begin
                    r_w[c]  <= w_new[c];
                    r_p1[c] <= $signed({{smf_pkg::FADER_W{r_smp[c][smf_pkg::SMP_W-1]}}, r_smp[c]})
                             * $signed({{smf_pkg::SMP_W{fader_eff[smf_pkg::FADER_W-1]}}, fader_eff});
                end
            end
            ST_MUL2: begin
                for (int c = 0; c < 2; c++) begin
                    r_p2[c] <= $signed({{smf_pkg::WGT_W{r_p1[c][smf_pkg::P1_W-1]}}, r_p1[c]})
                             * $signed({{smf_pkg::P1_W{1'b0}}, r_w[c]});
                end
            end
            ST_ABS: begin
                for (int c = 0; c < 2; c++) begin
                    r_neg[c] <= r_p2[c][smf_pkg::P2_W-1];
                    r_mag[c] <= r_p2[c][smf_pkg::P2_W-1] ? smf_pkg::MAG_W'(-r_p2[c])
                                                         : smf_pkg::MAG_W'(r_p2[c]);
                end
            end
            ST_RECIP: begin
                for (int c = 0; c < 2; c++) begin
                    r_q0[c] <= prod[c][smf_pkg::PROD_W-1:smf_pkg::RECIP_SH];
                end
            end
            ST_REM: begin
                for (int c = 0; c < 2; c++) begin
                    r_rem[c] <= smf_pkg::REM_W'(r_mag[c]
                              - smf_pkg::MAG_W'({{(smf_pkg::MAG_W-smf_pkg::Q_W){1'b0}}, r_q0[c]}
                                                * smf_pkg::MAG_W'(smf_pkg::DIV_C)));
                end
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/smf_queue.sv
// Small job queue between the front end and the accumulator back end.
`default_nettype none
module smf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  smf_pkg::t_job      i_job,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output smf_pkg::t_job      o_head
);
    smf_pkg::t_job                r_mem [smf_pkg::Q_DEPTH];
    logic [smf_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [smf_pkg::QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == smf_pkg::QCNT_W'(smf_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == smf_pkg::QPTR_W'(smf_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == smf_pkg::QPTR_W'(smf_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + smf_pkg::QCNT_W'(i_push) - smf_pkg::QCNT_W'(i_pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= smf_pkg::QCNT_W'(smf_pkg::Q_DEPTH)) else $error("queue count overflow");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow push");
`endif
endmodule
`default_nettype wire

FILE: hdl/smf_back.sv
// Back end: accumulator read-modify-write and mixed frame output register.
`default_nettype none
module smf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  smf_pkg::t_job      i_head,
    output logic               o_pop,
    smf_out_if.source          o_out
);
    localparam logic B_IDLE = 1'b0;
    localparam logic B_EXEC = 1'b1;

    logic                                r_state, n_state;
    smf_pkg::t_job                       r_job;
    logic                                r_ovalid;
    logic signed [smf_pkg::SMP_W-1:0]    r_oleft, r_oright;
    logic                                r_olast;

    logic [2*smf_pkg::SMP_W-1:0]         ram_rdata, ram_wdata;
    logic [smf_pkg::POS_W-1:0]           ram_addr;
    logic                                ram_we;
    logic [smf_pkg::SMP_W-1:0]           sum_l, sum_r;
    logic                                done;

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign done     = (r_state == B_EXEC) && (!r_job.lastb || !r_ovalid || o_out.ready);
    assign ram_we   = done;
    assign ram_addr = (r_state == B_EXEC) ? r_job.pos : i_head.pos;

    always_comb begin
        if (r_job.first) begin
            sum_l = r_job.left;
            sum_r = r_job.right;
        end else begin
            sum_l = ram_rdata[smf_pkg::SMP_W-1:0] + r_job.left;
            sum_r = ram_rdata[2*smf_pkg::SMP_W-1:smf_pkg::SMP_W] + r_job.right;
        end
        ram_wdata = {sum_r, sum_l};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (o_pop) n_state = B_EXEC;
            B_EXEC:  if (done) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    smf_ram #(
        .WIDTH(2 * smf_pkg::SMP_W),
        .DEPTH(smf_pkg::MAX_FRAMES)
    ) u_acc (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (o_pop),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign o_out.valid       = r_ovalid;
    assign o_out.mixed_left  = r_oleft;
    assign o_out.mixed_right = r_oright;
    assign o_out.frame_last  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done && r_job.lastb) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (done && r_job.lastb) begin
            r_oleft  <= sum_l;
            r_oright <= sum_r;
            r_olast  <= r_job.lastf;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/stereo_fader_pan_mixer.sv
// Top level: stereo fader/pan mixer with APB mode register.
//
//  channel   | dir | handshake      | payload
//  i_in      | in  | valid/ready    | left/right sample, fader, pan, buffer flags
//  o_out     | out | valid/ready    | mixed left/right, frame_last
//  APB       | in  | psel/penable   | mix_mode at byte address 0
//
//  An item passes the front end states accept, fader and pan multiply, magnitude,
//  reciprocal, remainder and push; no new item is taken until the push, which
//  waits while the queue is full. Back end: accumulator read, then add and write.
//  A two-entry queue and the output register keep the front accepting while a
//  result waits. Reset is synchronous; the accumulator is not cleared, so a
//  non-first frame must follow a first-buffer frame at that position.
`default_nettype none
module stereo_fader_pan_mixer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [smf_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    smf_in_if.sink                             i_in,
    smf_out_if.source                          o_out
);
    logic            r_mode;
    logic            push, pop, full, empty;
    smf_pkg::t_job   job, head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == smf_pkg::REG_MIX_MODE) ? {31'b0, r_mode} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == smf_pkg::REG_MIX_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    smf_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mode (r_mode),
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_job  (job)
    );

    smf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (job),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_head (head)
    );

    smf_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .i_head (head),
        .o_pop  (pop),
        .o_out  (o_out)
    );
endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for stereo_fader_pan_mixer: frame mixes with gain/pan checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam logic [smf_pkg::PADDR_W-1:0] MIX_MODE_ADDR =
        smf_pkg::PADDR_W'(4 * int'(smf_pkg::REG_MIX_MODE));

    typedef struct packed {
        logic signed [smf_pkg::SMP_W-1:0]   left;
        logic signed [smf_pkg::SMP_W-1:0]   right;
        logic signed [smf_pkg::FADER_W-1:0] fader;
        logic signed [smf_pkg::PAN_W-1:0]   pan;
        logic                               first;
        logic                               lastb;
        logic                               lastf;
    } t_frame_item;

    typedef struct packed {
        logic signed [smf_pkg::SMP_W-1:0] left;
        logic signed [smf_pkg::SMP_W-1:0] right;
        logic                             flast;
    } t_mixed_frame;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [smf_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    smf_in_if  in_if();
    smf_out_if out_if();

    stereo_fader_pan_mixer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [31:0]               mix_acc [smf_pkg::MAX_FRAMES];
    logic [smf_pkg::POS_W-1:0] mix_pos;
    logic                      gain_mode;

    // stimulus bookkeeping
    t_frame_item               frame_stim_q[$];
    t_mixed_frame              mixed_exp_q[$];
    logic [smf_pkg::POS_W-1:0] gen_pos;
    bit                        gen_written [smf_pkg::MAX_FRAMES];
    int                        gen_count;

    int   err_cnt;
    int   src_idle_pct;
    int   snk_idle_pct;
    logic in_fire;
    bit   hold_req;
    int   hold_cnt;
    int   quiet_cnt;
    t_frame_item  drv_item;
    t_mixed_frame mon_exp;
    t_mixed_frame mon_res;
    bit           mon_emits;

    function automatic logic signed [smf_pkg::SMP_W-1:0] apply_gain(
        logic signed [smf_pkg::SMP_W-1:0] s, int fdr, int wgt);
        int q;
        q = (int'(s) * fdr * wgt) / smf_pkg::DIV_C;
        if (q > 32767) q = 32767;
        else if (q < -32768) q = -32768;
        return smf_pkg::SMP_W'(q);
    endfunction

    function automatic void predict_mix(input t_frame_item it, output bit emits,
                                        output t_mixed_frame res);
        int fdr;
        int pn;
        int mag;
        int wl;
        int wr;
        logic signed [smf_pkg::SMP_W-1:0] l;
        logic signed [smf_pkg::SMP_W-1:0] r;
        logic [smf_pkg::SMP_W-1:0] nl;
        logic [smf_pkg::SMP_W-1:0] nr;
        l = it.left;
        r = it.right;
        if (gain_mode) begin
            fdr = int'(it.fader);
            pn  = int'(it.pan);
            if (fdr == -1 || fdr == 127) fdr = 127;
            mag = (pn < 0) ? -pn : pn;
            if (mag > 63) mag = 63;
            wl = 63;
            wr = 63;
            if (pn < 0) wr = 63 - mag;
            else if (pn > 0) wl = 63 - mag;
            l = apply_gain(l, fdr, wl);
            r = apply_gain(r, fdr, wr);
        end
        if (it.first) begin
            nl = l;
            nr = r;
        end else begin
            nl = mix_acc[mix_pos][15:0] + l;
            nr = mix_acc[mix_pos][31:16] + r;
        end
        mix_acc[mix_pos] = {nr, nl};
        mix_pos = (it.lastf || mix_pos == smf_pkg::POS_W'(smf_pkg::MAX_FRAMES - 1))
                  ? '0 : mix_pos + 1'b1;
        emits = it.lastb;
        res.left  = nl;
        res.right = nr;
        res.flast = it.lastf;
    endfunction

    // never lets a later buffer read an entry that was not written since reset
    function automatic void queue_frame(t_frame_item it);
        if (!it.first && !gen_written[gen_pos]) it.first = 1'b1;
        gen_written[gen_pos] = 1'b1;
        frame_stim_q.push_back(it);
        gen_pos = (it.lastf || gen_pos == smf_pkg::POS_W'(smf_pkg::MAX_FRAMES - 1))
                  ? '0 : gen_pos + 1'b1;
        gen_count++;
    endfunction

    function automatic t_frame_item mk_frame(int l, int r, int fdr, int pn,
                                             bit fb, bit lb, bit lf);
        t_frame_item it;
        it.left  = smf_pkg::SMP_W'(l);
        it.right = smf_pkg::SMP_W'(r);
        it.fader = smf_pkg::FADER_W'(fdr);
        it.pan   = smf_pkg::PAN_W'(pn);
        it.first = fb;
        it.lastb = lb;
        it.lastf = lf;
        return it;
    endfunction

    function automatic logic signed [smf_pkg::SMP_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return smf_pkg::SMP_W'(32767);
            1: return smf_pkg::SMP_W'(-32768);
            default: return smf_pkg::SMP_W'($urandom);
        endcase
    endfunction

    function automatic t_frame_item rand_frame();
        t_frame_item it;
        it.left  = rand_sample();
        it.right = rand_sample();
        it.fader = smf_pkg::FADER_W'($urandom);
        it.pan   = smf_pkg::PAN_W'($urandom);
        it.first = 1'($urandom);
        it.lastb = 1'($urandom);
        it.lastf = 1'($urandom);
        return it;
    endfunction

    // one mix: buffers x frames, first buffer overwrites, last buffer emits; a broken mix is cut short
    function automatic void queue_mix(int frames, int buffers, bit broken);
        t_frame_item it;
        logic signed [smf_pkg::FADER_W-1:0] fdr;
        logic signed [smf_pkg::PAN_W-1:0] pn;
        int cut;
        int k;
        if (gen_pos != '0) begin
            it = rand_frame();
            it.first = 1'b1;
            it.lastf = 1'b1;
            queue_frame(it);
        end
        cut = broken ? $urandom_range(1, frames * buffers - 1) : frames * buffers;
        k = 0;
        for (int b = 0; b < buffers; b++) begin
            case ($urandom_range(3))
                0: fdr = smf_pkg::FADER_W'(127);
                1: fdr = smf_pkg::FADER_W'(-1);
                2: fdr = smf_pkg::FADER_W'($urandom_range(127));
                default: fdr = smf_pkg::FADER_W'($urandom);
            endcase
            pn = smf_pkg::PAN_W'($urandom);
            for (int f = 0; f < frames; f++) begin
                if (k < cut) begin
                    it.left  = rand_sample();
                    it.right = rand_sample();
                    it.fader = fdr;
                    it.pan   = pn;
                    it.first = (b == 0);
                    it.lastb = (b == buffers - 1);
                    it.lastf = (f == frames - 1);
                    queue_frame(it);
                end
                k++;
            end
        end
    endfunction

    task automatic run_random(int n_items);
        int start;
        int pick;
        start = gen_count;
        while (gen_count - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                queue_mix($urandom_range(1, 8), $urandom_range(1, 4), 1'b0);
            end else if (pick < 88) begin
                queue_mix($urandom_range(2, 8), $urandom_range(1, 4), 1'b1);
            end else begin
                repeat ($urandom_range(1, 4)) queue_frame(rand_frame());
            end
        end
    endtask

    task automatic wait_idle();
        while (frame_stim_q.size() != 0 || in_if.valid || mixed_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input bit wr, input logic [smf_pkg::PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_mix_mode();
        logic [31:0] rd;
        apb_xfer(1'b0, MIX_MODE_ADDR, 32'd0, rd);
        if (rd[0] !== gain_mode) begin
            $error("mix_mode: expected %0d, actual %0d", gain_mode, rd[0]);
            err_cnt++;
        end
    endtask

    task automatic set_mix_mode(logic m);
        logic [31:0] rd;
        apb_xfer(1'b1, MIX_MODE_ADDR, {31'd0, m}, rd);
        gain_mode = m;
        check_mix_mode();
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_fire) begin
            if (frame_stim_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_item = frame_stim_q[0];
                frame_stim_q.delete(0);
                in_if.valid        <= 1'b1;
                in_if.left_sample  <= drv_item.left;
                in_if.right_sample <= drv_item.right;
                in_if.fader_level  <= drv_item.fader;
                in_if.pan_position <= drv_item.pan;
                in_if.first_buffer <= drv_item.first;
                in_if.last_buffer  <= drv_item.lastb;
                in_if.last_frame   <= drv_item.lastf;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            out_if.ready <= 1'b0;
            hold_cnt     <= hold_cnt + 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            drv_item.left  = in_if.left_sample;
            drv_item.right = in_if.right_sample;
            drv_item.fader = in_if.fader_level;
            drv_item.pan   = in_if.pan_position;
            drv_item.first = in_if.first_buffer;
            drv_item.lastb = in_if.last_buffer;
            drv_item.lastf = in_if.last_frame;
            predict_mix(drv_item, mon_emits, mon_res);
            if (mon_emits) mixed_exp_q.push_back(mon_res);
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (mixed_exp_q.size() == 0) begin
                $error("unexpected mixed frame: left %0d right %0d frame_last %0d",
                       out_if.mixed_left, out_if.mixed_right, out_if.frame_last);
                err_cnt++;
            end else begin
                mon_exp = mixed_exp_q[0];
                mixed_exp_q.delete(0);
                if (out_if.mixed_left !== mon_exp.left) begin
                    $error("mixed_left: expected %0d, actual %0d",
                           mon_exp.left, out_if.mixed_left);
                    err_cnt++;
                end
                if (out_if.mixed_right !== mon_exp.right) begin
                    $error("mixed_right: expected %0d, actual %0d",
                           mon_exp.right, out_if.mixed_right);
                    err_cnt++;
                end
                if (out_if.frame_last !== mon_exp.flast) begin
                    $error("frame_last: expected %0d, actual %0d",
                           mon_exp.flast, out_if.frame_last);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted item, result or register access
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (psel && penable)) begin
            quiet_cnt <= 0;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
        if (quiet_cnt >= QUIET_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_if.valid        = 1'b0;
        in_if.left_sample  = '0;
        in_if.right_sample = '0;
        in_if.fader_level  = '0;
        in_if.pan_position = '0;
        in_if.first_buffer = 1'b0;
        in_if.last_buffer  = 1'b0;
        in_if.last_frame   = 1'b0;
        out_if.ready       = 1'b0;
        in_fire            = 1'b0;
        hold_req           = 1'b0;
        hold_cnt           = 0;
        quiet_cnt          = 0;
        err_cnt            = 0;
        gen_count          = 0;
        gen_pos            = '0;
        mix_pos            = '0;
        gain_mode          = 1'b0;
        src_idle_pct       = 22;
        snk_idle_pct       = 48;
        for (int i = 0; i < smf_pkg::MAX_FRAMES; i++) begin
            gen_written[i] = 1'b0;
            mix_acc[i]     = '0;
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_mix_mode();

        // pre-fader: extremes and 16-bit wraparound over three buffers
        queue_frame(mk_frame(32767, -32768, 0, 0, 1, 0, 0));
        queue_frame(mk_frame(-1, 1, 127, 63, 1, 0, 1));
        queue_frame(mk_frame(1, -1, -128, -64, 0, 0, 0));
        queue_frame(mk_frame(-32768, 32767, -1, 0, 0, 0, 1));
        queue_frame(mk_frame(32767, 32767, 5, 5, 0, 1, 0));
        queue_frame(mk_frame(-32768, -32768, 5, 5, 0, 1, 1));
        wait_idle();

        // post-fader: unity, full pan, saturation at fader -128, pan -64, negative gain
        set_mix_mode(1'b1);
        queue_frame(mk_frame(32767, -32768, 127, 0, 1, 1, 1));
        queue_frame(mk_frame(32767, -32768, -1, 63, 1, 1, 1));
        queue_frame(mk_frame(-32768, 32767, -128, 0, 1, 1, 1));
        queue_frame(mk_frame(12345, -12345, 0, -63, 1, 1, 1));
        queue_frame(mk_frame(32767, 32767, 100, -64, 1, 1, 1));
        queue_frame(mk_frame(-20000, 20000, -50, 20, 1, 1, 1));
        queue_frame(mk_frame(1000, -1000, 64, -1, 1, 1, 1));
        queue_frame(mk_frame(1, -1, 1, 1, 1, 1, 1));
        queue_frame(mk_frame(30000, -30000, 127, 0, 1, 0, 1));
        queue_frame(mk_frame(30000, -30000, -1, 0, 0, 1, 1));
        wait_idle();

        // sender 22%, receiver 48%
        src_idle_pct = 22;
        snk_idle_pct = 48;
        run_random(150);
        wait_idle();

        set_mix_mode(1'b0);
        src_idle_pct = 48;
        snk_idle_pct = 22;
        run_random(90);
        wait_idle();
        run_random(95);
        wait_idle();

        // no idling; long receiver hold-off while the sender keeps offering
        set_mix_mode(1'b1);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++) begin
            drv_item = rand_frame();
            drv_item.first = 1'b1;
            drv_item.lastb = 1'b1;
            queue_frame(drv_item);
        end
        while (hold_cnt < HOLD_CYCLES) @(posedge i_clk);
        run_random(175);
        wait_idle();

        if (err_cnt == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
